### rtl/wfg_pkg.sv
package wfg_pkg;

  // transaction table size
  localparam int MAX_TRX = 16;
  // width of the slot fields on the ports
  localparam int SLOT_W  = 4;
  // width of a row index into the table
  localparam int IDX_W   = (MAX_TRX > 1) ? $clog2(MAX_TRX) : 1;
  // width of a count that reaches MAX_TRX itself
  localparam int DEP_W   = $clog2(MAX_TRX + 1);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_WAIT  = 2'd1,
    OP_LOCK  = 2'd2,
    OP_END   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_TRX   = 2'd1,
    STS_DEADLOCK = 2'd2,
    STS_FULL     = 2'd3
  } sts_t;

  typedef struct packed {
    op_t               opcode;
    logic [SLOT_W-1:0] trx_slot;
    logic [SLOT_W-1:0] holder_slot;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    sts_t              status;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  typedef logic [MAX_TRX-1:0] slot_mask_t;

  // field slot number to table index
  function automatic logic [IDX_W-1:0] to_idx(input logic [SLOT_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w[IDX_W-1:0];
  endfunction

  // table index to field, low bits only
  function automatic logic [SLOT_W-1:0] to_fld(input logic [IDX_W-1:0] i);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, i};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic in_range(input logic [SLOT_W-1:0] s);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{IDX_W{1'b0}}, s};
    return w < (IDX_W + SLOT_W)'(MAX_TRX);
  endfunction

  function automatic slot_mask_t slot_bit(input logic [IDX_W-1:0] i);
    slot_mask_t v;
    v    = '0;
    v[i] = 1'b1;
    return v;
  endfunction

  // priority encoder, lowest set bit
  function automatic logic [IDX_W-1:0] lowest_idx(input slot_mask_t m);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = MAX_TRX - 1; i >= 0; i--) begin
      if (m[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

### rtl/wait_for_graph_deadlock_detector.sv
// channel  ports                          payload      role
// in       in_valid  in_ready  in_data    in_item_t    one request per operation
// out      out_valid out_ready out_data   out_item_t   one result per request
//
// one request at a time; in_ready is high only while the controller is idle.
// a start sweeps the new slot's column, one table row a cycle; lock, end, a full table or
// a dead slot go straight to the result; a wait edge reads and writes back its row, and with
// last_edge a search follows: root row read, row evaluations and a step back to each parent.
// sync reset clears the live mask and control; table and stack memories need no clearing.
// a stalled output holds its result while a new request runs; a later result waits in
// the result state until the register frees.
module wait_for_graph_deadlock_detector
  import wfg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,  // waiting for a request
    S_CLR  = 7'b0000010,  // start: sweep rows, clear new slot's column
    S_EDGE = 7'b0000100,  // wait edge: row read back, set holder bit
    S_SRD  = 7'b0001000,  // search: read row of root after its write
    S_EVAL = 7'b0010000,  // search: row of top of stack is on wm_q
    S_POP  = 7'b0100000,  // search: stack entry below top is on stk_q
    S_RES  = 7'b1000000   // result waits for the output register
  } state_t;

  state_t             state_r, state_nxt;
  in_item_t           req_r, req_nxt;
  out_item_t          res_r, res_nxt;
  slot_mask_t         live_r, live_nxt;
  slot_mask_t         visited_r, visited_nxt;
  slot_mask_t         finished_r, finished_nxt;
  logic [DEP_W-1:0]   depth_r, depth_nxt;
  logic [DEP_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   u_r, u_nxt;
  logic [IDX_W-1:0]   s_r, s_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  // wait-for table: row = waiter, bit = holder
  slot_mask_t         wm_mem [MAX_TRX];
  slot_mask_t         wm_q;
  logic               wm_we;
  logic [IDX_W-1:0]   wm_waddr, wm_raddr;
  slot_mask_t         wm_wdata;

  // depth-first search stack
  logic [IDX_W-1:0]   stk_mem [MAX_TRX];
  logic [IDX_W-1:0]   stk_q;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_waddr, stk_raddr, stk_wdata;

  logic [IDX_W-1:0]   in_trx;
  logic               in_trx_live;
  slot_mask_t         free_mask;
  slot_mask_t         row_nb;
  slot_mask_t         fresh;
  logic [IDX_W-1:0]   next_idx;
  logic [DEP_W-1:0]   cnt_prev;
  logic [IDX_W-1:0]   prev_idx;
  logic [DEP_W-1:0]   dep_m2;
  logic [IDX_W-1:0]   req_trx;
  logic [IDX_W-1:0]   req_hold;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_trx      = to_idx(in_data.trx_slot);
  assign in_trx_live = in_range(in_data.trx_slot) && live_r[in_trx];
  assign free_mask   = ~live_r;
  assign req_trx     = to_idx(req_r.trx_slot);
  assign req_hold    = to_idx(req_r.holder_slot);

  // dead neighbors drop out of the search
  assign row_nb   = wm_q & live_r;
  assign fresh    = row_nb & ~visited_r;
  assign next_idx = lowest_idx(fresh);
  assign cnt_prev = cnt_r - DEP_W'(1);
  assign prev_idx = cnt_prev[IDX_W-1:0];
  assign dep_m2   = depth_r - DEP_W'(2);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    live_nxt      = live_r;
    visited_nxt   = visited_r;
    finished_nxt  = finished_r;
    depth_nxt     = depth_r;
    cnt_nxt       = cnt_r;
    u_nxt         = u_r;
    s_nxt         = s_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    wm_we     = 1'b0;
    wm_waddr  = req_trx;
    wm_wdata  = wm_q;
    wm_raddr  = u_r;
    stk_we    = 1'b0;
    stk_waddr = depth_r[IDX_W-1:0];
    stk_wdata = next_idx;
    stk_raddr = dep_m2[IDX_W-1:0];

    // output register drains independently of the controller
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        wm_raddr = in_trx;
        if (in_valid) begin
          req_nxt        = in_data;
          res_nxt.slot   = in_data.trx_slot;
          res_nxt.status = STS_OK;
          state_nxt      = S_RES;
          unique case (in_data.opcode)
            OP_START: begin
              if (|free_mask) begin
                s_nxt     = lowest_idx(free_mask);
                cnt_nxt   = '0;
                state_nxt = S_CLR;
              end else begin
                res_nxt.status = STS_FULL;
              end
            end
            OP_WAIT: begin
              if (in_trx_live) state_nxt = S_EDGE;
              else res_nxt.status = STS_NO_TRX;
            end
            OP_LOCK: begin
              if (!in_trx_live) res_nxt.status = STS_NO_TRX;
            end
            OP_END: begin
              if (in_trx_live) live_nxt[in_trx] = 1'b0;
              else res_nxt.status = STS_NO_TRX;
            end
          endcase
        end
      end

      S_CLR: begin
        // read row cnt; live row cnt-1 drops the new slot's bit; row s_r is zeroed
        wm_raddr = cnt_r[IDX_W-1:0];
        if (cnt_r != '0) begin
          wm_waddr = prev_idx;
          if (prev_idx == s_r) begin
            wm_we    = 1'b1;
            wm_wdata = '0;
          end else begin
            wm_we    = live_r[prev_idx];
            wm_wdata = wm_q & ~slot_bit(s_r);
          end
        end
        cnt_nxt = cnt_r + DEP_W'(1);
        if (cnt_r == DEP_W'(MAX_TRX)) begin
          live_nxt[s_r] = 1'b1;
          res_nxt.slot  = to_fld(s_r);
          state_nxt     = S_RES;
        end
      end

      S_EDGE: begin
        wm_we    = 1'b1;
        wm_waddr = req_trx;
        if (in_range(req_r.holder_slot) && live_r[req_hold])
          wm_wdata = wm_q | slot_bit(req_hold);
        else
          wm_wdata = wm_q;
        if (req_r.last_edge) begin
          u_nxt        = req_trx;
          visited_nxt  = slot_bit(req_trx);
          finished_nxt = '0;
          depth_nxt    = DEP_W'(1);
          stk_we       = 1'b1;
          stk_waddr    = '0;
          stk_wdata    = req_trx;
          state_nxt    = S_SRD;
        end else begin
          state_nxt = S_RES;
        end
      end

      S_SRD: begin
        // root row is read only after its write has landed
        wm_raddr  = u_r;
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (|(row_nb & visited_r & ~finished_r)) begin
          // back edge: waiter leaves the table
          live_nxt[req_trx] = 1'b0;
          res_nxt.status    = STS_DEADLOCK;
          state_nxt         = S_RES;
        end else if ((|fresh) && (depth_r < DEP_W'(MAX_TRX))) begin
          visited_nxt[next_idx] = 1'b1;
          stk_we                = 1'b1;
          stk_waddr             = depth_r[IDX_W-1:0];
          stk_wdata             = next_idx;
          depth_nxt             = depth_r + DEP_W'(1);
          u_nxt                 = next_idx;
          wm_raddr              = next_idx;
        end else begin
          finished_nxt[u_r] = 1'b1;
          depth_nxt         = depth_r - DEP_W'(1);
          if (depth_r == DEP_W'(1)) begin
            state_nxt = S_RES;
          end else begin
            stk_raddr = dep_m2[IDX_W-1:0];
            state_nxt = S_POP;
          end
        end
      end

      S_POP: begin
        u_nxt     = stk_q;
        wm_raddr  = stk_q;
        state_nxt = S_EVAL;
      end

      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wm_we) wm_mem[wm_waddr] <= wm_wdata;
    wm_q <= wm_mem[wm_raddr];
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    stk_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      visited_r   <= '0;
      finished_r  <= '0;
      depth_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      visited_r   <= visited_nxt;
      finished_r  <= finished_nxt;
      depth_r     <= depth_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    u_r        <= u_nxt;
    s_r        <= s_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // a finished node was always visited first
  a_fin_in_vis: assert property (@(posedge clk) disable iff (!rst_n)
    (finished_r & ~visited_r) == '0)
    else $error("finished node not visited");

  // search depth stays within the stack
  a_depth_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (depth_r != '0 && depth_r <= DEP_W'(MAX_TRX)))
    else $error("search depth out of range");

  // a reported deadlock has removed the waiter
  a_dl_removed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && res_r.status == STS_DEADLOCK) |-> !live_r[req_trx])
    else $error("deadlocked waiter still live");

  // a successful start leaves its slot live
  a_start_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RES && req_r.opcode == OP_START && res_r.status == STS_OK)
      |-> live_r[s_r])
    else $error("started slot not live");
`endif

endmodule
